// ----- sv/ets_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types, constants and the byte classifier of the token scanner.
// ----------------------------------------------------------------------------
package ets_pkg;

	localparam int LENGTH_BITS_DEF = 8;
	localparam int OFFSET_BITS_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int KIND_W  = 4;
	localparam int START_W = 32;
	localparam int LEN_W   = 8;

	typedef enum logic [3:0] {
		TK_NUMBER    = 4'd0,
		TK_IDENT     = 4'd1,
		TK_PLUS      = 4'd2,
		TK_MINUS     = 4'd3,
		TK_MUL       = 4'd4,
		TK_LPAREN    = 4'd5,
		TK_RPAREN    = 4'd6,
		TK_SEMI      = 4'd7,
		TK_GREATER   = 4'd8,
		TK_LESS      = 4'd9,
		TK_NOT_EQUAL = 4'd10,
		TK_EQUAL     = 4'd11,
		TK_COMMA     = 4'd12,
		TK_END       = 4'd13,
		TK_ERROR     = 4'd14
	} tok_kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_INT,
		MODE_DOT,
		MODE_FRAC,
		MODE_IDENT,
		MODE_LESS,
		MODE_HALT
	} scan_mode_t;

	typedef enum logic [3:0] {
		CC_SPACE,
		CC_DIGIT,
		CC_ALPHA,
		CC_DOT,
		CC_PLUS,
		CC_MINUS,
		CC_MUL,
		CC_LPAREN,
		CC_RPAREN,
		CC_SEMI,
		CC_GREATER,
		CC_LESS,
		CC_EQUAL,
		CC_COMMA,
		CC_BAD
	} chr_class_t;

	typedef struct packed {
		chr_class_t cls;
		logic       end_mark;
	} q_item_t;

	typedef struct packed {
		tok_kind_t          kind;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   length;
		logic               sat;
		logic               last;
	} tok_t;

	function automatic chr_class_t classify(input logic [7:0] c);
		chr_class_t r;
		case (c) inside
			8'h20, [8'h09:8'h0D]:       r = CC_SPACE;
			[8'h30:8'h39]:              r = CC_DIGIT;
			[8'h41:8'h5A], [8'h61:8'h7A]: r = CC_ALPHA;
			8'h2E:                      r = CC_DOT;
			8'h2B:                      r = CC_PLUS;
			8'h2D:                      r = CC_MINUS;
			8'h2A:                      r = CC_MUL;
			8'h28:                      r = CC_LPAREN;
			8'h29:                      r = CC_RPAREN;
			8'h3B:                      r = CC_SEMI;
			8'h3E:                      r = CC_GREATER;
			8'h3C:                      r = CC_LESS;
			8'h3D:                      r = CC_EQUAL;
			8'h2C:                      r = CC_COMMA;
			default:                    r = CC_BAD;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- sv/ets_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ets_in_if
// Byte channel into the scanner: one ASCII byte or an end-of-input mark.
// ----------------------------------------------------------------------------
interface ets_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_mark;

	modport source (output valid, output char_code, output end_mark, input ready);
	modport sink   (input valid, input char_code, input end_mark, output ready);
endinterface
`default_nettype wire

// ----- sv/ets_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ets_out_if
// Token channel out of the scanner: kind, start offset, length and flags.
// ----------------------------------------------------------------------------
interface ets_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [31:0] token_start;
	logic [7:0]  token_length;
	logic        length_saturated;
	logic        last_of_item;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output length_saturated, output last_of_item,
		input ready);
	modport sink   (input valid, input token_kind, input token_start,
		input token_length, input length_saturated, input last_of_item,
		output ready);
endinterface
`default_nettype wire

// ----- sv/ets_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ets_front
// Accepts input requests, classifies each byte and registers the class.
// ----------------------------------------------------------------------------
module ets_front
	import ets_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	ets_in_if.sink    bytes,
	output q_item_t   item,
	output logic      item_valid,
	input  wire logic item_ready
);

	logic    valid_s1;
	q_item_t item_s1;

	assign bytes.ready = !valid_s1 || item_ready;
	assign item_valid  = valid_s1;
	assign item        = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			item_s1.cls      <= classify(bytes.char_code);
			item_s1.end_mark <= bytes.end_mark;
		end
	end

endmodule
`default_nettype wire

// ----- sv/ets_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ets_queue
// Short FIFO of classified bytes between the front and the back end.
// ----------------------------------------------------------------------------
module ets_queue
	import ets_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire q_item_t  push_item,
	input  wire logic     push_valid,
	output logic          push_ready,
	output q_item_t       pop_item,
	output logic          pop_valid,
	input  wire logic     pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	q_item_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// ----- sv/ets_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ets_back
// Scan state machine: consumes classified bytes and delivers finished tokens
// through an output register with a one-token spill slot.
// ----------------------------------------------------------------------------
module ets_back
	import ets_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_item_t item,
	input  wire logic    item_valid,
	output logic         item_ready,
	ets_out_if.source    tokens
);

	scan_mode_t             mode_q, mode_d;
	logic [OFFSET_BITS-1:0] pend_start_q, pend_start_d;
	logic [LENGTH_BITS-1:0] pend_len_q, pend_len_d;
	logic                   pend_ovf_q, pend_ovf_d;
	logic [OFFSET_BITS-1:0] offset_q, offset_d;

	logic out_v_q;
	tok_t out_q;
	logic spill_v_q;
	tok_t spill_q;

	logic [1:0]             n_res;
	tok_t                   r0, r1;
	logic                   out_free;
	logic                   pop;

	// fresh-scan view of the current byte
	logic                   fr_emit;
	logic                   fr_begin;
	scan_mode_t             fr_mode;
	tok_t                   fr_tok;

	tok_t                   pend_tok;
	logic [LENGTH_BITS-1:0] ext_len;
	logic                   ext_ovf;
	logic [START_W-1:0]     off32;

	assign off32   = START_W'(offset_q);
	assign ext_len = (&pend_len_q) ? pend_len_q : pend_len_q + 1'b1;
	assign ext_ovf = pend_ovf_q || (&pend_len_q);

	always_comb begin
		pend_tok.kind   = TK_NUMBER;
		pend_tok.start  = START_W'(pend_start_q);
		pend_tok.length = LEN_W'(pend_len_q);
		pend_tok.sat    = pend_ovf_q;
		pend_tok.last   = 1'b0;
	end

	always_comb begin
		fr_emit      = 1'b1;
		fr_begin     = 1'b0;
		fr_mode      = MODE_IDLE;
		fr_tok.kind  = TK_ERROR;
		fr_tok.start = off32;
		fr_tok.length = LEN_W'(1);
		fr_tok.sat   = 1'b0;
		fr_tok.last  = 1'b0;
		case (item.cls)
			CC_SPACE:   fr_emit = 1'b0;
			CC_DIGIT: begin
				fr_emit  = 1'b0;
				fr_begin = 1'b1;
				fr_mode  = MODE_INT;
			end
			CC_ALPHA: begin
				fr_emit  = 1'b0;
				fr_begin = 1'b1;
				fr_mode  = MODE_IDENT;
			end
			CC_LESS: begin
				fr_emit  = 1'b0;
				fr_begin = 1'b1;
				fr_mode  = MODE_LESS;
			end
			CC_PLUS:    fr_tok.kind = TK_PLUS;
			CC_MINUS:   fr_tok.kind = TK_MINUS;
			CC_MUL:     fr_tok.kind = TK_MUL;
			CC_LPAREN:  fr_tok.kind = TK_LPAREN;
			CC_RPAREN:  fr_tok.kind = TK_RPAREN;
			CC_SEMI:    fr_tok.kind = TK_SEMI;
			CC_GREATER: fr_tok.kind = TK_GREATER;
			CC_EQUAL:   fr_tok.kind = TK_EQUAL;
			CC_COMMA:   fr_tok.kind = TK_COMMA;
			default: begin
				// stray dot or unknown byte
				fr_tok.length = '0;
				fr_mode       = MODE_HALT;
			end
		endcase
	end

	always_comb begin
		tok_t err_tok;
		tok_t end_tok;
		logic flush_fresh;
		err_tok.kind   = TK_ERROR;
		err_tok.start  = off32;
		err_tok.length = '0;
		err_tok.sat    = 1'b0;
		err_tok.last   = 1'b0;
		end_tok        = err_tok;
		end_tok.kind   = TK_END;

		mode_d       = mode_q;
		pend_start_d = pend_start_q;
		pend_len_d   = pend_len_q;
		pend_ovf_d   = pend_ovf_q;
		offset_d     = offset_q;
		n_res        = 2'd0;
		r0           = pend_tok;
		r1           = end_tok;
		flush_fresh  = 1'b0;

		if (mode_q == MODE_HALT) begin
			n_res = 2'd0;
		end else if (item.end_mark) begin
			offset_d = '0;
			mode_d   = MODE_IDLE;
			case (mode_q)
				MODE_DOT: begin
					r0       = err_tok;
					n_res    = 2'd1;
					mode_d   = MODE_HALT;
					offset_d = offset_q;
				end
				MODE_INT, MODE_FRAC: n_res = 2'd2;
				MODE_IDENT: begin
					r0.kind = TK_IDENT;
					n_res   = 2'd2;
				end
				MODE_LESS: begin
					r0.kind = TK_LESS;
					n_res   = 2'd2;
				end
				default: begin
					r0    = end_tok;
					n_res = 2'd1;
				end
			endcase
		end else begin
			offset_d = offset_q + 1'b1;
			case (mode_q)
				MODE_INT: begin
					if (item.cls == CC_DIGIT || item.cls == CC_DOT) begin
						pend_len_d = ext_len;
						pend_ovf_d = ext_ovf;
						if (item.cls == CC_DOT) mode_d = MODE_DOT;
					end else begin
						flush_fresh = 1'b1;
					end
				end
				MODE_DOT: begin
					if (item.cls == CC_DIGIT) begin
						pend_len_d = ext_len;
						pend_ovf_d = ext_ovf;
						mode_d     = MODE_FRAC;
					end else begin
						r0     = err_tok;
						n_res  = 2'd1;
						mode_d = MODE_HALT;
					end
				end
				MODE_FRAC: begin
					if (item.cls == CC_DIGIT) begin
						pend_len_d = ext_len;
						pend_ovf_d = ext_ovf;
					end else begin
						flush_fresh = 1'b1;
					end
				end
				MODE_IDENT: begin
					r0.kind = TK_IDENT;
					if (item.cls == CC_DIGIT || item.cls == CC_ALPHA) begin
						pend_len_d = ext_len;
						pend_ovf_d = ext_ovf;
					end else begin
						flush_fresh = 1'b1;
					end
				end
				MODE_LESS: begin
					r0.kind = TK_LESS;
					if (item.cls == CC_GREATER) begin
						pend_len_d = ext_len;
						pend_ovf_d = ext_ovf;
						r0.kind    = TK_NOT_EQUAL;
						r0.length  = LEN_W'(ext_len);
						r0.sat     = ext_ovf;
						n_res      = 2'd1;
						mode_d     = MODE_IDLE;
					end else begin
						flush_fresh = 1'b1;
					end
				end
				default: begin
					r0     = fr_tok;
					n_res  = fr_emit ? 2'd1 : 2'd0;
					mode_d = fr_mode;
					if (fr_begin) begin
						pend_start_d = offset_q;
						pend_len_d   = LENGTH_BITS'(1);
						pend_ovf_d   = 1'b0;
					end
				end
			endcase
			if (flush_fresh) begin
				r1     = fr_tok;
				n_res  = fr_emit ? 2'd2 : 2'd1;
				mode_d = fr_mode;
				if (fr_begin) begin
					pend_start_d = offset_q;
					pend_len_d   = LENGTH_BITS'(1);
					pend_ovf_d   = 1'b0;
				end
			end
		end
		r0.last = (n_res == 2'd1);
		r1.last = 1'b1;
	end

	// a spilled second token drains before the next request is taken
	assign out_free   = !out_v_q || tokens.ready;
	assign pop        = item_valid && !spill_v_q && (n_res == 2'd0 || out_free);
	assign item_ready = !spill_v_q && (n_res == 2'd0 || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			pend_start_q <= '0;
			pend_len_q   <= '0;
			pend_ovf_q   <= 1'b0;
			offset_q     <= '0;
			out_v_q      <= 1'b0;
			spill_v_q    <= 1'b0;
		end else begin
			if (pop) begin
				mode_q       <= mode_d;
				pend_start_q <= pend_start_d;
				pend_len_q   <= pend_len_d;
				pend_ovf_q   <= pend_ovf_d;
				offset_q     <= offset_d;
			end
			if (out_free) begin
				out_v_q <= spill_v_q || (pop && n_res != 2'd0);
			end
			if (spill_v_q && out_free) begin
				spill_v_q <= 1'b0;
			end else if (pop && n_res == 2'd2) begin
				spill_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= spill_v_q ? spill_q : r0;
		end
		if (pop && n_res == 2'd2) begin
			spill_q <= r1;
		end
	end

	assign tokens.valid            = out_v_q;
	assign tokens.token_kind       = out_q.kind;
	assign tokens.token_start      = out_q.start;
	assign tokens.token_length     = out_q.length;
	assign tokens.length_saturated = out_q.sat;
	assign tokens.last_of_item     = out_q.last;

endmodule
`default_nettype wire

// ----- sv/expression_token_scanner_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// expression_token_scanner_unit
// Streaming lexical scanner for a small expression language.
// ----------------------------------------------------------------------------
// The scanner takes one byte request per cycle while the queue has room and
// returns tokens with kind, start offset and length. A byte that only extends
// or opens a token, or that gives one token, leaves the scan engine free for
// the next byte. A byte that closes a pending token and also gives a token of
// its own, and an end mark behind a pending token, give two tokens: the second
// waits in the spill slot, and the scan engine takes no new byte until it has
// moved to the output register. A byte passes through the classifier stage,
// the queue and the output register. An invalid byte or a dot without a
// following digit gives an error token and halts the scanner until reset.
module expression_token_scanner_unit
	import ets_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ets_in_if.sink    bytes,
	ets_out_if.source tokens
);

	q_item_t f_item;
	logic    f_valid;
	logic    f_ready;
	q_item_t b_item;
	logic    b_valid;
	logic    b_ready;

	ets_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.item       (f_item),
		.item_valid (f_valid),
		.item_ready (f_ready)
	);

	ets_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (f_item),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_item   (b_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready)
	);

	ets_back #(
		.LENGTH_BITS (LENGTH_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (b_item),
		.item_valid (b_valid),
		.item_ready (b_ready),
		.tokens     (tokens)
	);

endmodule
`default_nettype wire
